// ===== src/json_string_unescape_utf8_core_assert.svh =====
// ----------------------------------------------------------------------------
// JSON string unescape core - assertion macros
// Shared property shapes on the core clock with the synchronous reset masked.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_ASSERT_SVH

// Same-cycle implication.
`define JSU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define JSU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape package
// Command word passed from the decoder front to the byte emitter, queue
// sizing and the character codes both sides use.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int QCw    = $clog2(QDepth + 1);

    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChU         = 8'h75;

    // One decoded input byte, emitted in order: high unit, code point or
    // replay, literal.
    typedef struct packed {
        logic             hi_en;    // encode pending high surrogate (3 bytes)
        logic [15:0]      hi_unit;
        logic             cp_en;    // encode code point (1..4 bytes)
        logic [20:0]      cp;
        logic             rep_en;   // 'u' then rep_cnt held digits
        logic [1:0]       rep_cnt;
        logic [2:0][7:0]  held;
        logic             lit_en;   // one literal byte
        logic [7:0]       lit;
        logic             last;     // caused by the final byte of the string
    } t_cmd;

endpackage

// ===== src/jsu_front.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape front
// Escape and \u parser: takes one raw byte per word and issues at most one command for it.
// ----------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_q_full,
    output logic       o_in_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_ESC,
        PH_HEX,
        PH_HI_BS,
        PH_HI_U,
        PH_HI_HEX
    } t_phase;

    localparam logic [15:0] SurHiMin = 16'hD800;
    localparam logic [15:0] SurHiMax = 16'hDBFF;
    localparam logic [15:0] SurLoMin = 16'hDC00;
    localparam logic [15:0] SurLoMax = 16'hDFFF;
    localparam logic [20:0] SupBase  = 21'h10000;

    t_phase          r_phase, n_phase;
    logic [1:0]      r_cnt, n_cnt;
    logic [2:0][7:0] r_held, n_held;
    logic [15:0]     r_high, n_high;
    logic [15:0]     r_acc, n_acc;

    logic        accept;
    logic [4:0]  hx;
    logic [15:0] take_acc;
    logic [20:0] pair_cp;
    logic        done;
    logic        is_bs;
    logic        is_u;
    logic        cont;
    t_cmd        cmd;

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] e);
        logic [7:0] r;
        case (e)
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = e;
        endcase
        return r;
    endfunction

    function automatic logic is_high(input logic [15:0] v);
        return (v >= SurHiMin) && (v <= SurHiMax);
    endfunction

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign hx         = hex_value(i_in_byte);
    assign take_acc   = {r_acc[11:0], hx[3:0]};
    assign pair_cp    = {1'b0, r_high[9:0], take_acc[9:0]} + SupBase;
    assign done       = (r_cnt == 2'd3);
    assign is_bs      = (i_in_byte == ChBackslash);
    assign is_u       = (i_in_byte == ChU);
    // a backslash opens an escape unless the string ends here
    assign cont       = is_bs && !i_in_last;

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_held      = r_held;
        n_high      = r_high;
        n_acc       = r_acc;
        cmd         = '0;
        cmd.hi_unit = r_high;
        cmd.lit     = i_in_byte;
        cmd.last    = i_in_last;
        cmd.held    = r_held;

        if (accept) begin
            case (r_phase)
                PH_ESC: begin
                    if (is_u && !i_in_last) begin
                        n_phase = PH_HEX;
                        n_cnt   = 2'd0;
                        n_acc   = 16'd0;
                    end else begin
                        cmd.lit_en = 1'b1;
                        cmd.lit    = escape_map(i_in_byte);
                        n_phase    = PH_NORMAL;
                    end
                end
                PH_HEX, PH_HI_HEX: begin
                    if (hx[4]) begin
                        n_acc = take_acc;
                        if (!done) n_held[r_cnt] = i_in_byte;
                        cmd.held = n_held;
                        n_cnt    = r_cnt + 2'd1;
                        if (done) begin
                            if (r_phase == PH_HI_HEX &&
                                take_acc >= SurLoMin && take_acc <= SurLoMax) begin
                                cmd.cp_en = 1'b1;
                                cmd.cp    = pair_cp;
                                n_phase   = PH_NORMAL;
                            end else begin
                                cmd.hi_en = (r_phase == PH_HI_HEX);
                                if (is_high(take_acc) && !i_in_last) begin
                                    n_high  = take_acc;
                                    n_phase = PH_HI_BS;
                                end else begin
                                    cmd.cp_en = 1'b1;
                                    cmd.cp    = {5'd0, take_acc};
                                    n_phase   = PH_NORMAL;
                                end
                            end
                        end else if (i_in_last) begin
                            // too few digits: replay including this one
                            cmd.hi_en   = (r_phase == PH_HI_HEX);
                            cmd.rep_en  = 1'b1;
                            cmd.rep_cnt = r_cnt + 2'd1;
                        end
                    end else begin
                        // bad digit: replay, then treat the byte as text
                        cmd.hi_en   = (r_phase == PH_HI_HEX);
                        cmd.rep_en  = 1'b1;
                        cmd.rep_cnt = r_cnt;
                        cmd.lit_en  = !cont;
                        n_cnt       = 2'd0;
                        n_phase     = cont ? PH_ESC : PH_NORMAL;
                    end
                end
                PH_HI_BS: begin
                    if (cont) begin
                        n_phase = PH_HI_U;
                    end else begin
                        cmd.hi_en  = 1'b1;
                        cmd.lit_en = 1'b1;
                        n_phase    = PH_NORMAL;
                    end
                end
                PH_HI_U: begin
                    if (is_u && !i_in_last) begin
                        n_phase = PH_HI_HEX;
                        n_cnt   = 2'd0;
                        n_acc   = 16'd0;
                    end else begin
                        cmd.hi_en  = 1'b1;
                        cmd.lit_en = 1'b1;
                        cmd.lit    = escape_map(i_in_byte);
                        n_phase    = PH_NORMAL;
                    end
                end
                default: begin
                    cmd.lit_en = !cont;
                    n_phase    = cont ? PH_ESC : PH_NORMAL;
                end
            endcase
            if (i_in_last) begin
                n_phase = PH_NORMAL;
                n_cnt   = 2'd0;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.hi_en || cmd.cp_en || cmd.rep_en || cmd.lit_en);

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_cnt   <= 2'd0;
            r_high  <= 16'd0;
            r_acc   <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_high  <= n_high;
            r_acc   <= n_acc;
        end
    end

endmodule

// ===== src/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape command queue
// Short first-in first-out store of commands between front and emitter.
// ----------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd             r_mem [QDepth];
    logic [QAw-1:0]   r_wr;
    logic [QAw-1:0]   r_rd;
    logic [QCw-1:0]   r_count;

    assign o_full  = (r_count == QCw'(QDepth));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QAw'(1);
            if (i_pop)  r_rd <= r_rd + QAw'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCw'(1);
                2'b01:   r_count <= r_count - QCw'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/jsu_back.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape emitter
// Expands the head command into UTF-8 bytes, one output word per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    input  logic       i_ready,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_run_last,
    output logic       o_string_last
);

    localparam logic [7:0] Lead2 = 8'hC0;
    localparam logic [7:0] Lead3 = 8'hE0;
    localparam logic [7:0] Lead4 = 8'hF0;
    localparam logic [7:0] Cont  = 8'h80;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } t_enc;

    function automatic t_enc encode(input logic [20:0] cp);
        t_enc e;
        e = '0;
        if (cp <= 21'h7F) begin
            e.len  = 3'd1;
            e.b[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            e.len  = 3'd2;
            e.b[0] = Lead2 | {3'd0, cp[10:6]};
            e.b[1] = Cont  | {2'd0, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            e.len  = 3'd3;
            e.b[0] = Lead3 | {4'd0, cp[15:12]};
            e.b[1] = Cont  | {2'd0, cp[11:6]};
            e.b[2] = Cont  | {2'd0, cp[5:0]};
        end else begin
            e.len  = 3'd4;
            e.b[0] = Lead4 | {5'd0, cp[20:18]};
            e.b[1] = Cont  | {2'd0, cp[17:12]};
            e.b[2] = Cont  | {2'd0, cp[11:6]};
            e.b[3] = Cont  | {2'd0, cp[5:0]};
        end
        return e;
    endfunction

    logic [2:0] r_k;
    t_enc       hi_enc;
    t_enc       cp_enc;
    logic [1:0] hl;
    logic [2:0] ml;
    logic [3:0] total;
    logic [2:0] j;
    logic [1:0] hidx;
    logic       fin;

    assign hi_enc = encode({5'd0, i_cmd.hi_unit});
    assign cp_enc = encode(i_cmd.cp);
    assign hl     = i_cmd.hi_en ? 2'd3 : 2'd0;
    assign ml     = i_cmd.cp_en  ? cp_enc.len :
                    i_cmd.rep_en ? 3'd1 + {1'b0, i_cmd.rep_cnt} : 3'd0;
    assign total  = {2'd0, hl} + {1'b0, ml} + {3'd0, i_cmd.lit_en};
    assign j      = r_k - {1'b0, hl};
    assign hidx   = j[1:0] - 2'd1;
    assign fin    = ({1'b0, r_k} + 4'd1) == total;

    always_comb begin
        if (r_k < {1'b0, hl}) begin
            o_byte = hi_enc.b[r_k[1:0]];
        end else if (j < ml) begin
            if (i_cmd.cp_en)  o_byte = cp_enc.b[j[1:0]];
            else if (j == 3'd0) o_byte = ChU;
            else              o_byte = i_cmd.held[hidx];
        end else begin
            o_byte = i_cmd.lit;
        end
    end

    assign o_valid       = i_valid;
    assign o_run_last    = fin;
    assign o_string_last = fin && i_cmd.last;
    assign o_pop         = i_valid && i_ready && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 3'd0;
        end else if (i_valid && i_ready) begin
            r_k <= fin ? 3'd0 : r_k + 3'd1;
        end
    end

endmodule

// ===== src/json_string_unescape_utf8_core.sv =====
// A raw byte's command is registered in the queue; the emitter offers decoded bytes from the queue head.
// Throughput: one raw byte per cycle in while the queue has room; one decoded byte per cycle
//   out while the receiver is ready, and one raw byte yields 0 to 8 decoded bytes.
// A four-entry command queue between parser and emitter absorbs multi-byte runs.
// Reset (synchronous, active low) returns the parser to plain text and empties the queue.
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8 core
// Decodes escapes and \u sequences (with surrogate pairs) of a JSON string
// body into UTF-8 bytes over stream buses.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_core_assert.svh"

module json_string_unescape_utf8_core
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [0:0] m_axis_tuser,   // [0] run_last
    output logic       m_axis_tlast    // string_last
);

    // Front to queue
    t_cmd front_cmd;
    logic front_push;

    // Queue to emitter
    t_cmd head_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;

    logic run_last;

    // Parse escapes; a word is taken whenever the queue has room.
    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_byte  (s_axis_tdata),
        .i_in_last  (s_axis_tlast),
        .i_q_full   (q_full),
        .o_in_ready (s_axis_tready),
        .o_push     (front_push),
        .o_cmd      (front_cmd)
    );

    // Hold pending commands so either side can stall alone.
    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    // Expand the head command; drop it after its final byte is taken.
    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (!q_empty),
        .i_cmd         (head_cmd),
        .i_ready       (m_axis_tready),
        .o_pop         (q_pop),
        .o_valid       (m_axis_tvalid),
        .o_byte        (m_axis_tdata),
        .o_run_last    (run_last),
        .o_string_last (m_axis_tlast)
    );

    assign m_axis_tuser = run_last;

    // The end of the string always closes a run.
    `JSU_ASSERT_IMP(a_str_last_ends_run, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0], "string end without run end")
    // A final input byte always leaves work for the emitter.
    `JSU_ASSERT_NXT(a_last_makes_output, s_axis_tvalid && s_axis_tready && s_axis_tlast, m_axis_tvalid, "final byte produced no output")
    // An empty queue can never refuse input.
    `JSU_ASSERT_IMP(a_empty_is_ready, !m_axis_tvalid, s_axis_tready, "input stalled with empty queue")

endmodule

// ===== tb/sv/tb_json_string_unescape_utf8_core.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape core - self-checking testbench
// Feeds raw string-body bytes into the slave stream and checks every decoded
// UTF-8 word on the master stream against an in-bench decoder. A short
// directed pass covers the corner cases. Random strings follow, built mostly
// from well-formed escapes and surrogate pairs with some noise. Both sides
// idle and stall in phases.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_core;
    import jsu_pkg::*;

    localparam int ResetCycles = 11;
    localparam int QuietLimit  = 4000;   // cycles with no word moving on either side
    localparam int TailCycles  = 12;
    localparam int HoldCycles  = 64;     // long receiver hold-off
    localparam int PhaseItems  = 86;     // random raw words per idling phase
    localparam int MaxRun      = 8;      // most decoded words one raw word can cause

    // Character codes
    localparam logic [7:0] Ch0     = 8'h30;
    localparam logic [7:0] Ch9     = 8'h39;
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpF   = 8'h46;
    localparam logic [7:0] ChLowA  = 8'h61;
    localparam logic [7:0] ChLowB  = 8'h62;
    localparam logic [7:0] ChLowF  = 8'h66;
    localparam logic [7:0] ChLowN  = 8'h6E;
    localparam logic [7:0] ChLowR  = 8'h72;
    localparam logic [7:0] ChLowT  = 8'h74;
    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTilde = 8'h7E;
    localparam logic [7:0] CtlBs   = 8'h08;
    localparam logic [7:0] CtlTab  = 8'h09;
    localparam logic [7:0] CtlLf   = 8'h0A;
    localparam logic [7:0] CtlFf   = 8'h0C;
    localparam logic [7:0] CtlCr   = 8'h0D;

    // Surrogate ranges and UTF-8 lead/continuation marks
    localparam logic [15:0] SurHiLo = 16'hD800;
    localparam logic [15:0] SurHiHi = 16'hDBFF;
    localparam logic [15:0] SurLoLo = 16'hDC00;
    localparam logic [15:0] SurLoHi = 16'hDFFF;
    localparam logic [7:0]  Lead2   = 8'hC0;
    localparam logic [7:0]  Lead3   = 8'hE0;
    localparam logic [7:0]  Lead4   = 8'hF0;
    localparam logic [7:0]  ContMk  = 8'h80;

    // ------------------------------------------------------------------------
    // Scoreboard: decodes each accepted raw word and queues the UTF-8 words
    // it must produce, then matches the master stream against that queue.
    // ------------------------------------------------------------------------
    class unescape_scoreboard;
        typedef enum logic [2:0] {
            ST_TEXT,      // plain text
            ST_ESC,       // after a backslash
            ST_HEX,       // gathering \u digits
            ST_HI_WAIT,   // high surrogate held, waiting for a backslash
            ST_HI_ESC,    // high surrogate held, backslash seen
            ST_HI_HEX     // high surrogate held, gathering the second \u digits
        } decode_phase_t;

        typedef struct packed {
            logic [7:0] data;
            logic       run_last;
            logic       string_last;
        } utf8_word_t;

        decode_phase_t phase;
        logic [2:0]    digit_count;
        logic [7:0]    held_digits [4];
        logic [15:0]   high_unit;
        logic [15:0]   hex_accum;
        logic [7:0]    run_bytes [$];
        utf8_word_t    expected_utf8 [$];
        int            fails;

        function new();
            phase       = ST_TEXT;
            digit_count = '0;
            foreach (held_digits[i]) held_digits[i] = '0;
            high_unit   = '0;
            hex_accum   = '0;
            fails       = 0;
        endfunction

        static function int hex_nibble(logic [7:0] c);
            if (c >= Ch0 && c <= Ch9) return int'(c - Ch0);
            if (c >= ChLowA && c <= ChLowF) return int'(c - ChLowA) + 10;
            if (c >= ChUpA && c <= ChUpF) return int'(c - ChUpA) + 10;
            return -1;
        endfunction

        function logic [7:0] map_escape(logic [7:0] e);
            case (e)
                ChLowB:  return CtlBs;
                ChLowF:  return CtlFf;
                ChLowN:  return CtlLf;
                ChLowR:  return CtlCr;
                ChLowT:  return CtlTab;
                default: return e;
            endcase
        endfunction

        function void emit_byte(logic [7:0] b);
            if (run_bytes.size() < MaxRun) run_bytes.push_back(b);
        endfunction

        function void encode_cp(logic [20:0] cp);
            if (cp <= 21'h7F) begin
                emit_byte(cp[7:0]);
            end else if (cp <= 21'h7FF) begin
                emit_byte(Lead2 | 8'(cp >> 6));
                emit_byte(ContMk | 8'(cp & 21'h3F));
            end else if (cp <= 21'hFFFF) begin
                emit_byte(Lead3 | 8'(cp >> 12));
                emit_byte(ContMk | 8'((cp >> 6) & 21'h3F));
                emit_byte(ContMk | 8'(cp & 21'h3F));
            end else begin
                emit_byte(Lead4 | 8'(cp >> 18));
                emit_byte(ContMk | 8'((cp >> 12) & 21'h3F));
                emit_byte(ContMk | 8'((cp >> 6) & 21'h3F));
                emit_byte(ContMk | 8'(cp & 21'h3F));
            end
        endfunction

        function void plain_text(logic [7:0] b, logic last);
            if (b == ChBackslash && !last) begin
                phase = ST_ESC;
            end else begin
                emit_byte(b);
                phase = ST_TEXT;
            end
        endfunction

        // Give up on a \u escape: emit 'u' and the digits taken so far.
        function void replay_digits();
            emit_byte(ChU);
            for (int k = 0; k < digit_count && k < 4; k++) emit_byte(held_digits[k]);
            digit_count = '0;
            phase       = ST_TEXT;
        endfunction

        function void close_cp(logic [15:0] cp, logic last);
            if (cp >= SurHiLo && cp <= SurHiHi && !last) begin
                high_unit = cp;
                phase     = ST_HI_WAIT;
            end else begin
                encode_cp(cp);
                phase = ST_TEXT;
            end
        endfunction

        function logic take_digit(logic [7:0] b, int h);
            held_digits[digit_count[1:0]] = b;
            hex_accum   = {hex_accum[11:0], h[3:0]};
            digit_count = digit_count + 3'd1;
            return digit_count >= 3'd4;
        endfunction

        function void note_raw_byte(logic [7:0] b, logic last);
            int          h;
            logic [15:0] lo;
            logic [20:0] pair_cp;
            int          n;
            h = hex_nibble(b);
            run_bytes.delete();
            case (phase)
                ST_ESC: begin
                    if (b == ChU && !last) begin
                        phase       = ST_HEX;
                        digit_count = '0;
                        hex_accum   = '0;
                    end else begin
                        emit_byte(map_escape(b));
                        phase = ST_TEXT;
                    end
                end
                ST_HEX: begin
                    if (h >= 0) begin
                        if (take_digit(b, h)) begin
                            digit_count = '0;
                            close_cp(hex_accum, last);
                        end else if (last) begin
                            replay_digits();
                        end
                    end else begin
                        replay_digits();
                        plain_text(b, last);
                    end
                end
                ST_HI_WAIT: begin
                    if (b == ChBackslash && !last) begin
                        phase = ST_HI_ESC;
                    end else begin
                        encode_cp(high_unit);
                        plain_text(b, last);
                    end
                end
                ST_HI_ESC: begin
                    if (b == ChU && !last) begin
                        phase       = ST_HI_HEX;
                        digit_count = '0;
                        hex_accum   = '0;
                    end else begin
                        encode_cp(high_unit);
                        emit_byte(map_escape(b));
                        phase = ST_TEXT;
                    end
                end
                ST_HI_HEX: begin
                    if (h >= 0) begin
                        if (take_digit(b, h)) begin
                            lo          = hex_accum;
                            digit_count = '0;
                            if (lo >= SurLoLo && lo <= SurLoHi) begin
                                pair_cp = 21'h10000 + ((21'(high_unit) - 21'(SurHiLo)) << 10)
                                        + (21'(lo) - 21'(SurLoLo));
                                encode_cp(pair_cp);
                                phase = ST_TEXT;
                            end else begin
                                encode_cp(high_unit);
                                close_cp(lo, last);
                            end
                        end else if (last) begin
                            encode_cp(high_unit);
                            replay_digits();
                        end
                    end else begin
                        encode_cp(high_unit);
                        replay_digits();
                        plain_text(b, last);
                    end
                end
                default: plain_text(b, last);
            endcase

            if (last) begin
                phase       = ST_TEXT;
                digit_count = '0;
            end

            n = run_bytes.size();
            for (int k = 0; k < n; k++)
                expected_utf8.push_back('{data: run_bytes[k], run_last: (k == n - 1),
                                          string_last: (k == n - 1) && last});
        endfunction

        function void check_utf8_byte(logic [7:0] data, logic run_last, logic string_last);
            utf8_word_t exp_w;
            if (expected_utf8.size() == 0) begin
                $error("out_byte: no word expected, got %02h", data);
                fails++;
                return;
            end
            exp_w = expected_utf8.pop_front();
            if (data !== exp_w.data) begin
                $error("out_byte: expected %02h, got %02h", exp_w.data, data);
                fails++;
            end
            if (run_last !== exp_w.run_last) begin
                $error("run_last: expected %0b, got %0b", exp_w.run_last, run_last);
                fails++;
            end
            if (string_last !== exp_w.string_last) begin
                $error("string_last: expected %0b, got %0b", exp_w.string_last, string_last);
                fails++;
            end
        endfunction

        function int pending();
            return expected_utf8.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;    // last_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic [0:0] m_axis_tuser;            // [0] run_last
    logic       m_axis_tlast;            // string_last

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    json_string_unescape_utf8_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    unescape_scoreboard sb;
    int         idle_pct     = 0;   // chance the sender idles before a word
    int         stall_pct    = 0;   // chance the receiver drops tready in a cycle
    bit         hold_request = 1'b0;
    int         items_sent   = 0;
    int         quiet_cycles = 0;
    logic [7:0] raw_text [$];       // one string body, built then sent

    // ------------------------------------------------------------------------
    // Monitor: note every accepted raw word, check every accepted decoded
    // word, and count cycles in which nothing moves for the watchdog.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_raw_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_utf8_byte(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog: end the run once the streams have sat still too long.
    initial begin
        while (quiet_cycles < QuietLimit) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request so the
    // command queue fills and the block pushes back on the sender.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    // Offer one raw word, idling first at random; hold tvalid high after the
    // handshake so back-to-back words need no reassertion.
    task automatic send_raw_byte(logic [7:0] b, logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_raw_text();
        foreach (raw_text[i]) send_raw_byte(raw_text[i], i == raw_text.size() - 1);
    endtask

    // Drop tvalid and wait until every decoded word has come out.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic append_text(string s);
        for (int i = 0; i < s.len(); i++) raw_text.push_back(s[i]);
    endtask

    // Hex digit in either case, picked at random.
    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return Ch0 + 8'(n);
        return ($urandom_range(0, 1) ? ChLowA : ChUpA) + 8'(n - 4'd10);
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (unescape_scoreboard::hex_nibble(b) >= 0) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic put_escape_u(logic [15:0] cp);
        raw_text.push_back(ChBackslash);
        raw_text.push_back(ChU);
        for (int i = 3; i >= 0; i--) raw_text.push_back(hex_char(cp[i*4 +: 4]));
    endtask

    // Append one random token: plain text, a simple or unknown escape, a \u
    // escape, a surrogate pair (sometimes spoilt) or a truncated \u.
    task automatic add_token();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            if ($urandom_range(0, 3) != 0)
                raw_text.push_back(8'($urandom_range(ChSpace, ChTilde)));
            else
                raw_text.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 45) begin
            raw_text.push_back(ChBackslash);
            case ($urandom_range(0, 7))
                0:       raw_text.push_back(ChLowB);
                1:       raw_text.push_back(ChLowF);
                2:       raw_text.push_back(ChLowN);
                3:       raw_text.push_back(ChLowR);
                4:       raw_text.push_back(ChLowT);
                5:       raw_text.push_back(ChQuote);
                6:       raw_text.push_back(ChSlash);
                default: raw_text.push_back(ChBackslash);
            endcase
        end else if (pick < 50) begin
            // unknown escape: any byte after the backslash
            raw_text.push_back(ChBackslash);
            raw_text.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 72) begin
            case ($urandom_range(0, 3))
                0:       put_escape_u(16'($urandom_range(0, 16'h7F)));
                1:       put_escape_u(16'($urandom_range(16'h80, 16'h7FF)));
                2:       put_escape_u(16'($urandom_range(16'h800, 16'hFFFF)));
                default: put_escape_u(16'($urandom_range(SurHiLo, SurLoHi)));
            endcase
        end else if (pick < 88) begin
            put_escape_u(16'($urandom_range(SurHiLo, SurHiHi)));
            case ($urandom_range(0, 5))
                0:       put_escape_u(16'($urandom_range(0, 16'hFFFF)));
                1:       ;   // leave the high surrogate alone; the next token follows
                default: put_escape_u(16'($urandom_range(SurLoLo, SurLoHi)));
            endcase
        end else begin
            // truncated \u, now and then after a high surrogate
            if ($urandom_range(0, 2) == 0) put_escape_u(16'($urandom_range(SurHiLo, SurHiHi)));
            raw_text.push_back(ChBackslash);
            raw_text.push_back(ChU);
            repeat ($urandom_range(0, 3)) raw_text.push_back(hex_char(4'($urandom_range(0, 15))));
            if ($urandom_range(0, 1)) raw_text.push_back(non_hex_byte());
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: byte extremes, simple and unknown escapes, a lone
        // trailing backslash
        raw_text.delete();
        raw_text.push_back(8'h00);
        append_text("\\t\\q\\");
        send_raw_text();
        // surrogate pair in mixed case
        raw_text.delete();
        append_text("\\uD83D\\ude00");
        send_raw_text();
        // bad hex digit, then the top byte value to close the string
        raw_text.delete();
        append_text("\\u1G");
        raw_text.push_back(8'hFF);
        send_raw_text();
        // escape 'u' on the final word
        raw_text.delete();
        append_text("\\u");
        send_raw_text();
        // high surrogate at the end of the string
        raw_text.delete();
        append_text("\\ud800");
        send_raw_text();
        wait_for_drain();

        // Random strings over four idling phases; drain between phases.
        for (int ph = 0; ph < 4; ph++) begin
            int phase_end;
            case (ph)
                0: begin
                    idle_pct     = 0;
                    stall_pct    = 0;
                    hold_request = 1'b1;   // long hold-off while the sender keeps going
                end
                1: begin
                    idle_pct  = 51;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 51;
                end
                default: begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase
            phase_end = items_sent + PhaseItems;
            while (items_sent < phase_end) begin
                raw_text.delete();
                repeat ($urandom_range(1, 6)) add_token();
                send_raw_text();
            end
            wait_for_drain();
        end

        // Let any stray word surface before the verdict.
        repeat (TailCycles) @(posedge i_clk);
        if (sb.fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
